FILE: sv/ctc_greedy_decoder_assert.svh
// Assertion macros for the CTC greedy decoder.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef CTC_GREEDY_DECODER_ASSERT_SVH
`define CTC_GREEDY_DECODER_ASSERT_SVH

`ifndef SYNTH
// checked outside reset
`define CTCGD_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define CTCGD_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTCGD_ASSERT_RST(lbl, clk, rst, prop, msg)
`define CTCGD_ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/ctcgd_pkg.sv
// Shared constants and controller/datapath interface types for the CTC greedy decoder.
// No dependencies.
package ctcgd_pkg;

  localparam int MAX_CLASSES_DEF = 8192;
  localparam int MAX_LABELS_DEF  = 1024;
  localparam int SCORE_BITS_DEF  = 16;

  localparam int DICT_W = 14;
  localparam logic [DICT_W-1:0] DICT_RESET = 14'd8192;

  localparam int SUM_W  = 27;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int MEAN_W = 16;

  localparam logic KIND_LABEL = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic load_end;
  } cmd_t;

  typedef struct packed {
    logic emit_label;
    logic close_seq;
    logic div_done;
  } sts_t;

endpackage

FILE: sv/ctcgd_div.sv
// Restoring divider, one quotient bit per cycle, for the mean confidence.
// Depends on ctcgd_pkg and ctc_greedy_decoder_assert.svh.
`include "ctc_greedy_decoder_assert.svh"

module ctcgd_div import ctcgd_pkg::*; #(
  parameter int COUNT_W = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [SUM_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [COUNT_W-1:0] rem;
  logic [SUM_W-1:0]   quo;
  logic [COUNT_W:0]   shifted;
  logic [COUNT_W:0]   diff;
  logic               ge;

  assign shifted = {rem, quo[SUM_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  assign done     = !busy;
  assign quotient = quo;

  `CTCGD_ASSERT_RST(a_busy_cnt, clk, rst, busy |-> cnt != '0, "divider busy with no bits left")

endmodule

FILE: sv/ctcgd_datapath.sv
// Datapath: argmax over a step, label filter, sum and count, output record register.
// Depends on ctcgd_pkg, ctcgd_div and ctc_greedy_decoder_assert.svh.
`include "ctc_greedy_decoder_assert.svh"

module ctcgd_datapath import ctcgd_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_LABELS  = MAX_LABELS_DEF,
  parameter int SCORE_BITS  = SCORE_BITS_DEF,
  localparam int CLASS_W    = $clog2(MAX_CLASSES),
  localparam int COUNT_W    = $clog2(MAX_LABELS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  dict_size_we,
  input  logic [DICT_W-1:0]     dict_size,
  input  logic [SCORE_BITS-1:0] score,
  input  logic                  last_class,
  input  logic                  last_step,
  output logic                  kind,
  output logic [CLASS_W-1:0]    label,
  output logic [SCORE_BITS-1:0] label_score,
  output logic [MEAN_W-1:0]     avg_score,
  output logic [COUNT_W-1:0]    label_count,
  output logic                  last
);

  localparam int CMP_W = (CLASS_W > DICT_W) ? CLASS_W : DICT_W;
  localparam int ADD_W = ((SUM_W > SCORE_BITS) ? SUM_W : SCORE_BITS) + 1;

  logic [DICT_W-1:0]     dict_reg;
  logic [CLASS_W-1:0]    class_index;
  logic [CLASS_W-1:0]    best_class;
  logic [SCORE_BITS-1:0] best_score;
  logic [CLASS_W-1:0]    previous_label;
  logic [SUM_W-1:0]      score_sum;
  logic [COUNT_W-1:0]    emitted_count;

  logic                  take;
  logic [CLASS_W-1:0]    win_class;
  logic [SCORE_BITS-1:0] win_score;
  logic                  new_label;
  logic                  in_dict;
  logic                  can_count;
  logic [ADD_W-1:0]      sum_wide;
  logic [SUM_W-1:0]      sum_next;
  logic [COUNT_W-1:0]    count_next;
  logic                  div_done;
  logic [SUM_W-1:0]      quotient;
  logic [MEAN_W-1:0]     mean_val;

  assign take      = (class_index == '0) || (score > best_score);
  assign win_class = take ? class_index : best_class;
  assign win_score = take ? score : best_score;
  assign new_label = (win_class != '0) && (win_class != previous_label);
  assign in_dict   = CMP_W'(win_class) < CMP_W'(dict_reg);
  assign can_count = emitted_count < COUNT_W'(MAX_LABELS);

  assign sum_wide   = ADD_W'(score_sum) + ADD_W'(win_score);
  assign sum_next   = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_wide);
  assign count_next = can_count ? emitted_count + 1'b1 : emitted_count;

  assign sts.emit_label = last_class && new_label && in_dict;
  assign sts.close_seq  = last_class && last_step;
  assign sts.div_done   = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      dict_reg       <= DICT_RESET;
      class_index    <= '0;
      best_class     <= '0;
      best_score     <= '0;
      previous_label <= '0;
      score_sum      <= '0;
      emitted_count  <= '0;
    end else begin
      if (dict_size_we) begin
        dict_reg <= dict_size;
      end
      if (cmd.accept) begin
        best_class <= win_class;
        best_score <= win_score;
        if (!last_class) begin
          if (class_index != CLASS_W'(MAX_CLASSES - 1)) begin
            class_index <= class_index + 1'b1;
          end
        end else begin
          class_index <= '0;
          if (last_step || win_class == '0) begin
            previous_label <= '0;
          end else if (new_label) begin
            previous_label <= win_class;
          end
          if (sts.emit_label && can_count) begin
            emitted_count <= count_next;
            score_sum     <= sum_next;
          end
        end
      end else if (cmd.load_end) begin
        score_sum     <= '0;
        emitted_count <= '0;
      end
    end
  end

  ctcgd_div #(
    .COUNT_W(COUNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(score_sum),
    .divisor (emitted_count),
    .done    (div_done),
    .quotient(quotient)
  );

  always_comb begin
    if (emitted_count == '0) begin
      mean_val = '0;
    end else if (|quotient[SUM_W-1:MEAN_W]) begin
      mean_val = '1;
    end else begin
      mean_val = quotient[MEAN_W-1:0];
    end
  end

  // output record register
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.emit_label) begin
      kind        <= KIND_LABEL;
      label       <= win_class;
      label_score <= win_score;
      avg_score   <= '0;
      label_count <= count_next;
      last        <= !last_step;
    end else if (cmd.load_end) begin
      kind        <= KIND_END;
      label       <= '0;
      label_score <= '0;
      avg_score   <= mean_val;
      label_count <= emitted_count;
      last        <= 1'b1;
    end
  end

  `CTCGD_ASSERT_RST(a_count_bound, clk, rst, emitted_count <= COUNT_W'(MAX_LABELS), "label count beyond limit")

endmodule

FILE: sv/ctcgd_ctrl.sv
// Controller: input/output handshakes, sequence-end divide and end record sequencing.
// Depends on ctcgd_pkg and ctc_greedy_decoder_assert.svh.
`include "ctc_greedy_decoder_assert.svh"

module ctcgd_ctrl import ctcgd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free      = !out_valid || !out_stall;
  assign in_stall      = (state != S_RUN) || !out_free;
  assign cmd.accept    = in_valid && !in_stall;
  assign cmd.div_start = state == S_LOAD;
  assign cmd.load_end  = (state == S_END) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (cmd.accept && sts.close_seq) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_END;
        end
      end
      S_END: begin
        if (cmd.load_end) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_comb begin
    priority if ((cmd.accept && sts.emit_label) || cmd.load_end) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `CTCGD_ASSERT_CLK(a_rst_idle, clk, rst |=> !out_valid && state == S_RUN, "reset left block busy")
  `CTCGD_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "stalled transaction dropped")
  `CTCGD_ASSERT_RST(a_end_after_div, clk, rst, state == S_END |-> sts.div_done, "end record before divide done")

endmodule

FILE: sv/ctc_greedy_decoder.sv
// CTC greedy decoder top level: controller plus datapath.
// Depends on ctcgd_pkg, ctcgd_ctrl, ctcgd_datapath.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  score, last_class, last_step
//   output    out_valid/out_stall  kind, label, label_score, avg_score, label_count, last
//   config    dict_size_we         dict_size
//
// One score per cycle while the output register is free; a step close does not hold the input.
// A sequence close blocks input through the load, divide (27-bit bit-serial) and end
// states, plus any output stall before the end record is loaded.
// Synchronous active-high reset; dict_size returns to 8192.
// A held output transaction stalls the input side only while out_stall is high.
module ctc_greedy_decoder import ctcgd_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_LABELS  = MAX_LABELS_DEF,
  parameter int SCORE_BITS  = SCORE_BITS_DEF,
  localparam int CLASS_W    = $clog2(MAX_CLASSES),
  localparam int COUNT_W    = $clog2(MAX_LABELS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  dict_size_we,
  input  logic [DICT_W-1:0]     dict_size,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SCORE_BITS-1:0] score,
  input  logic                  last_class,
  input  logic                  last_step,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [CLASS_W-1:0]    label,
  output logic [SCORE_BITS-1:0] label_score,
  output logic [MEAN_W-1:0]     avg_score,
  output logic [COUNT_W-1:0]    label_count,
  output logic                  last
);

  cmd_t cmd;
  sts_t sts;

  ctcgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ctcgd_datapath #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_LABELS (MAX_LABELS),
    .SCORE_BITS (SCORE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .dict_size_we(dict_size_we),
    .dict_size   (dict_size),
    .score       (score),
    .last_class  (last_class),
    .last_step   (last_step),
    .kind        (kind),
    .label       (label),
    .label_score (label_score),
    .avg_score   (avg_score),
    .label_count (label_count),
    .last        (last)
  );

endmodule
